### rtl/als_pkg.sv
package als_pkg;

    localparam int SAMPLE_BITS  = 24;
    localparam int PEAK_BITS    = SAMPLE_BITS - 1;
    localparam int SQUARE_BITS  = 2 * SAMPLE_BITS;
    localparam int SUM_BITS     = 64;
    localparam int ROOT_BITS    = SUM_BITS / 2;
    localparam int COUNT_BITS   = 17;
    localparam int MAX_BLOCK    = 65536;
    localparam int CREST_BITS   = 17;
    localparam int CREST_SHIFT  = 8;
    localparam int CREST_NUM_BITS = SAMPLE_BITS + CREST_SHIFT;

    // shared unit: partial remainder covers sqrt (2 bits/step) and divide
    localparam int REM_BITS     = ROOT_BITS + 4;
    localparam int STEP_BITS    = $clog2(SUM_BITS + 1);

    localparam int DIV_STEPS    = SUM_BITS;
    localparam int SQRT_STEPS   = ROOT_BITS;
    localparam int CREST_STEPS  = ROOT_BITS;

    localparam int S_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = SAMPLE_BITS + PEAK_BITS + SAMPLE_BITS + CREST_BITS;
    localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

    typedef enum logic {
        OP_DIV,
        OP_SQRT
    } als_op_t;

    typedef struct packed {
        logic square;
        logic add;
        logic clear;
    } als_acc_ctrl_t;

    typedef struct packed {
        logic [SUM_BITS-1:0]    sum;
        logic [COUNT_BITS-1:0]  count;
        logic [PEAK_BITS-1:0]   peak;
        logic [SAMPLE_BITS-1:0] mag;
    } als_stats_t;

    typedef struct packed {
        logic                  start;
        als_op_t               op;
        logic [SUM_BITS-1:0]   num;
        logic [ROOT_BITS-1:0]  den;
        logic [STEP_BITS-1:0]  steps;
    } als_iter_cmd_t;

endpackage

### rtl/audio_level_statistics.sv
// Block level meter for signed Q1.23 audio. Each sample request carries one
// sample in s_tdata with s_tlast on the final sample of a block; the block
// answers with one result per block: RMS, peak floored at zero, largest
// magnitude and crest factor (magnitude / RMS, unsigned Q9.8, truncated,
// zero when RMS is zero, saturating at all ones). Samples beyond 65536 in one
// block are ignored, but their tlast still closes the block. Each sample is
// accepted, squared and accumulated through a single multiplier and 64-bit
// adder. After the final sample, one restoring subtract unit does the
// 64-step mean division, the 32-step square root and the 32-step crest
// division in turn, each launched from its own start state, and the result
// register is then loaded. A zero RMS skips the crest division. The result
// register holds while the next block streams in; a block end waits there
// only if the previous result has not yet been taken.
module audio_level_statistics (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [als_pkg::S_TDATA_BITS-1:0]  s_tdata,  // [23:0] sample_value
    input  logic                              s_tlast,  // block_end
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [23:0] rms_level, [46:24] peak_level, [70:47] peak_magnitude,
    // [87:71] crest_ratio
    output logic [als_pkg::M_TDATA_BITS-1:0]  m_tdata
);
    import als_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ADD,
        ST_DIV_GO,
        ST_DIV,
        ST_SQRT_GO,
        ST_SQRT,
        ST_CREST_GO,
        ST_CREST,
        ST_OUT
    } state_t;

    state_t                   state_reg;
    logic [SAMPLE_BITS-1:0]   sample_reg;
    logic                     last_reg;
    logic [ROOT_BITS-1:0]     rms_reg;
    logic [CREST_BITS-1:0]    crest_reg;
    logic                     m_tvalid_reg;
    logic [M_TDATA_BITS-1:0]  m_tdata_reg;

    als_acc_ctrl_t            acc_ctrl;
    als_stats_t               stats;
    als_iter_cmd_t            iter_cmd;
    logic [SUM_BITS-1:0]      iter_result;
    logic                     iter_done;
    logic                     out_free;
    logic [CREST_NUM_BITS-1:0] crest_num;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign crest_num = {stats.mag, CREST_SHIFT'(0)};

    always_comb begin
        acc_ctrl.square = (state_reg == ST_SQUARE);
        acc_ctrl.add    = (state_reg == ST_ADD);
        acc_ctrl.clear  = (state_reg == ST_OUT) && out_free;
    end

    always_comb begin
        iter_cmd.start = 1'b0;
        iter_cmd.op    = OP_DIV;
        iter_cmd.num   = stats.sum;
        iter_cmd.den   = ROOT_BITS'(stats.count);
        iter_cmd.steps = STEP_BITS'(DIV_STEPS);
        unique case (state_reg)
            ST_DIV_GO: begin
                iter_cmd.start = (stats.count != '0);
            end
            ST_SQRT_GO: begin
                iter_cmd.start = 1'b1;
                iter_cmd.op    = OP_SQRT;
                iter_cmd.num   = iter_result;
                iter_cmd.steps = STEP_BITS'(SQRT_STEPS);
            end
            ST_CREST_GO: begin
                // dividend sits in the top half so half the steps suffice
                iter_cmd.start = 1'b1;
                iter_cmd.num   = {ROOT_BITS'(crest_num), ROOT_BITS'(0)};
                iter_cmd.den   = rms_reg;
                iter_cmd.steps = STEP_BITS'(CREST_STEPS);
            end
            default: begin
                iter_cmd.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if ((state_reg == ST_OUT) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        sample_reg <= s_tdata[SAMPLE_BITS-1:0];
                        last_reg   <= s_tlast;
                        state_reg  <= ST_SQUARE;
                    end
                end
                ST_SQUARE: begin
                    state_reg <= ST_ADD;
                end
                ST_ADD: begin
                    state_reg <= last_reg ? ST_DIV_GO : ST_IDLE;
                end
                ST_DIV_GO: begin
                    if (stats.count == '0) begin
                        rms_reg   <= '0;
                        crest_reg <= '0;
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (iter_done) begin
                        state_reg <= ST_SQRT_GO;
                    end
                end
                ST_SQRT_GO: begin
                    state_reg <= ST_SQRT;
                end
                ST_SQRT: begin
                    if (iter_done) begin
                        rms_reg <= iter_result[ROOT_BITS-1:0];
                        if (iter_result[ROOT_BITS-1:0] == '0) begin
                            crest_reg <= '0;
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_CREST_GO;
                        end
                    end
                end
                ST_CREST_GO: begin
                    state_reg <= ST_CREST;
                end
                ST_CREST: begin
                    if (iter_done) begin
                        crest_reg <= (iter_result[SUM_BITS-1:CREST_BITS] != '0)
                                   ? '1 : iter_result[CREST_BITS-1:0];
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // hold until the previous result has been taken
                    if (out_free) begin
                        m_tdata_reg  <= M_TDATA_BITS'({crest_reg, stats.mag, stats.peak,
                                                       rms_reg[SAMPLE_BITS-1:0]});
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    als_accum u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (acc_ctrl),
        .sample  (sample_reg),
        .stats   (stats)
    );

    als_iter u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (iter_cmd),
        .result  (iter_result),
        .done    (iter_done)
    );

endmodule

### rtl/als_accum.sv
module als_accum (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  als_pkg::als_acc_ctrl_t        ctrl,
    input  logic [als_pkg::SAMPLE_BITS-1:0] sample,
    output als_pkg::als_stats_t           stats
);
    import als_pkg::*;

    logic [SUM_BITS-1:0]    sum_reg;
    logic [COUNT_BITS-1:0]  count_reg;
    logic [PEAK_BITS-1:0]   peak_reg;
    logic [SAMPLE_BITS-1:0] mag_reg;
    logic [SQUARE_BITS-1:0] sq_reg;
    logic                   hit_reg;

    logic                   neg;
    logic [SAMPLE_BITS-1:0] mag;
    logic                   in_range;
    logic [SUM_BITS:0]      sum_wide;

    assign neg      = sample[SAMPLE_BITS-1];
    assign mag      = neg ? (~sample + SAMPLE_BITS'(1)) : sample;
    assign in_range = count_reg < COUNT_BITS'(MAX_BLOCK);
    assign sum_wide = {1'b0, sum_reg} + (SUM_BITS + 1)'(sq_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            count_reg <= '0;
            peak_reg  <= '0;
            mag_reg   <= '0;
            hit_reg   <= 1'b0;
        end else if (ctrl.clear) begin
            sum_reg   <= '0;
            count_reg <= '0;
            peak_reg  <= '0;
            mag_reg   <= '0;
            hit_reg   <= 1'b0;
        end else if (ctrl.square) begin
            // samples past the block limit leave every statistic alone
            hit_reg <= in_range;
            sq_reg  <= mag * mag;
            if (in_range) begin
                if (!neg && sample[PEAK_BITS-1:0] > peak_reg) begin
                    peak_reg <= sample[PEAK_BITS-1:0];
                end
                if (mag > mag_reg) begin
                    mag_reg <= mag;
                end
            end
        end else if (ctrl.add && hit_reg) begin
            // saturate the sum on carry out
            sum_reg   <= sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
            count_reg <= count_reg + COUNT_BITS'(1);
        end
    end

    assign stats.sum   = sum_reg;
    assign stats.count = count_reg;
    assign stats.peak  = peak_reg;
    assign stats.mag   = mag_reg;

endmodule

### rtl/als_iter.sv
module als_iter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  als_pkg::als_iter_cmd_t        cmd,
    output logic [als_pkg::SUM_BITS-1:0]  result,
    output logic                          done
);
    import als_pkg::*;

    als_op_t               op_reg;
    logic [SUM_BITS-1:0]   num_reg;
    logic [REM_BITS-1:0]   rem_reg;
    logic [SUM_BITS-1:0]   q_reg;
    logic [ROOT_BITS-1:0]  den_reg;
    logic [STEP_BITS-1:0]  left_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [REM_BITS-1:0]   shifted;
    logic [REM_BITS-1:0]   trial;
    logic [SUM_BITS-1:0]   num_next;
    logic [REM_BITS:0]     diff;
    logic                  ge;
    logic [REM_BITS-1:0]   rem_next;
    logic [SUM_BITS-1:0]   q_next;

    // one restoring step: bring in one (divide) or two (root) bits, trial subtract
    always_comb begin
        unique case (op_reg)
            OP_SQRT: begin
                shifted  = {rem_reg[REM_BITS-3:0], num_reg[SUM_BITS-1 -: 2]};
                trial    = {q_reg[REM_BITS-3:0], 2'b01};
                num_next = {num_reg[SUM_BITS-3:0], 2'b00};
            end
            default: begin
                shifted  = {rem_reg[REM_BITS-2:0], num_reg[SUM_BITS-1]};
                trial    = REM_BITS'(den_reg);
                num_next = {num_reg[SUM_BITS-2:0], 1'b0};
            end
        endcase
        diff     = {1'b0, shifted} - {1'b0, trial};
        ge       = !diff[REM_BITS];
        rem_next = ge ? diff[REM_BITS-1:0] : shifted;
        q_next   = {q_reg[SUM_BITS-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
                op_reg   <= cmd.op;
                num_reg  <= cmd.num;
                den_reg  <= cmd.den;
                left_reg <= cmd.steps;
                rem_reg  <= '0;
                q_reg    <= '0;
            end else if (busy_reg) begin
                num_reg  <= num_next;
                rem_reg  <= rem_next;
                q_reg    <= q_next;
                left_reg <= left_reg - STEP_BITS'(1);
                if (left_reg == STEP_BITS'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign result = q_reg;
    assign done   = done_reg;

endmodule

### rtl/als_checker.sv
module als_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [als_pkg::S_TDATA_BITS-1:0]  s_tdata,
    input  logic                              s_tlast,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [als_pkg::M_TDATA_BITS-1:0]  m_tdata
);

    // a waiting result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // s_tready is low in the cycle after each accepted sample
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("sample accepted on consecutive cycles");

    // the block end cannot produce its result on the very next cycle
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !$rose(m_tvalid))
        else $error("result appeared before the block was evaluated");

    a_crest_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[23:0] == 24'd0) |-> (m_tdata[87:71] == 17'd0))
        else $error("crest factor nonzero with zero rms");

    a_peak_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, m_tdata[46:24]} <= m_tdata[70:47]))
        else $error("peak exceeds peak magnitude");

endmodule

bind audio_level_statistics als_checker u_als_checker (.*);

### dv/tb_audio_level_statistics.sv
module tb_audio_level_statistics;
    import als_pkg::*;

    localparam int CREST_LIMIT = (1 << CREST_BITS) - 1;
    localparam int HOLD_CYCLES = 600;

    // lowest field in the lowest bits, as on m_tdata
    typedef struct packed {
        logic [CREST_BITS-1:0]  crest;
        logic [SAMPLE_BITS-1:0] mag;
        logic [PEAK_BITS-1:0]   peak;
        logic [SAMPLE_BITS-1:0] rms;
    } level_report_t;

    typedef enum int {
        MIX_FULL,
        MIX_SMALL,
        MIX_NEGATIVE,
        MIX_EXTREME
    } sample_mix_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata;  // [23:0] sample_value
    logic                    s_tlast;  // block_end
    logic                    m_tvalid;
    logic                    m_tready;
    // [23:0] rms_level, [46:24] peak_level, [70:47] peak_magnitude,
    // [87:71] crest_ratio
    logic [M_TDATA_BITS-1:0] m_tdata;

    // predictor state
    logic [SUM_BITS-1:0]    meter_sum;
    logic [COUNT_BITS-1:0]  meter_count;
    logic [PEAK_BITS-1:0]   meter_peak;
    logic [SAMPLE_BITS-1:0] meter_mag;
    level_report_t          pending_levels[$];

    level_report_t seen_level;
    level_report_t want_level;
    int            error_count;
    bit            steady;
    int            holds_asked;
    int            holds_served;
    int            hold_left;

    audio_level_statistics i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    function automatic logic [ROOT_BITS-1:0] floor_root(input logic [SUM_BITS-1:0] value);
        logic [SUM_BITS-1:0] rest;
        logic [SUM_BITS-1:0] root;
        logic [SUM_BITS-1:0] probe;
        rest  = value;
        root  = '0;
        probe = 64'h4000_0000_0000_0000;
        while (probe > rest)
            probe = probe >> 2;
        while (probe != 0) begin
            if (rest >= root + probe) begin
                rest = rest - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root[ROOT_BITS-1:0];
    endfunction

    function automatic void take_sample(input logic [SAMPLE_BITS-1:0] value,
                                        input logic last_one);
        logic                   neg;
        logic [SAMPLE_BITS-1:0] mag;
        logic [SUM_BITS-1:0]    square;
        logic [ROOT_BITS-1:0]   root;
        logic [SUM_BITS-1:0]    ratio;
        level_report_t          report;
        // samples past the block limit are dropped from every statistic
        if (meter_count < MAX_BLOCK) begin
            neg    = value[SAMPLE_BITS-1];
            mag    = neg ? (~value + 1'b1) : value;
            square = SUM_BITS'(mag) * SUM_BITS'(mag);
            if (meter_sum > ~square)
                meter_sum = '1;
            else
                meter_sum = meter_sum + square;
            meter_count = meter_count + 1'b1;
            if (!neg && value[PEAK_BITS-1:0] > meter_peak)
                meter_peak = value[PEAK_BITS-1:0];
            if (mag > meter_mag)
                meter_mag = mag;
        end
        if (last_one) begin
            root  = '0;
            ratio = '0;
            if (meter_count != 0)
                root = floor_root(meter_sum / meter_count);
            if (root != 0) begin
                ratio = (SUM_BITS'(meter_mag) << CREST_SHIFT) / root;
                if (ratio > CREST_LIMIT)
                    ratio = CREST_LIMIT;
            end
            report.rms   = root[SAMPLE_BITS-1:0];
            report.peak  = meter_peak;
            report.mag   = meter_mag;
            report.crest = ratio[CREST_BITS-1:0];
            pending_levels.push_back(report);
            meter_sum   = '0;
            meter_count = '0;
            meter_peak  = '0;
            meter_mag   = '0;
        end
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample(input sample_mix_t mix);
        int pick;
        case (mix)
            MIX_SMALL: begin
                pick = int'($urandom_range(128)) - 64;
                return pick[SAMPLE_BITS-1:0];
            end
            MIX_NEGATIVE: begin
                return SAMPLE_BITS'($urandom | (1 << (SAMPLE_BITS - 1)));
            end
            MIX_EXTREME: begin
                case ($urandom_range(4))
                    0: return 24'h7F_FFFF;
                    1: return 24'h80_0000;
                    2: return 24'h00_0000;
                    3: return 24'h00_0001;
                    default: return 24'hFF_FFFF;
                endcase
            end
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] value, input logic last_one);
        if (!steady && $urandom_range(99) < 10) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last_one;
        do @(posedge aclk); while (!s_tready);
        take_sample(value, last_one);
    endtask

    task automatic send_block(input int len, input sample_mix_t mix);
        for (int i = 0; i < len; i++)
            send_sample(pick_sample(mix), i == len - 1);
    endtask

    task automatic test_single_extremes();
        send_sample(24'h7F_FFFF, 1'b1);
        send_sample(24'h80_0000, 1'b1);
        send_sample(24'h00_0001, 1'b1);
        send_sample(24'hFF_FFFF, 1'b1);
    endtask

    task automatic test_zero_and_negative_blocks();
        // zero rms forces a zero crest
        send_sample(24'h00_0000, 1'b0);
        send_sample(24'h00_0000, 1'b0);
        send_sample(24'h00_0000, 1'b1);
        // peak must stay at zero
        send_sample(-24'sd5, 1'b0);
        send_sample(-24'sd100, 1'b0);
        send_sample(24'h80_0000, 1'b0);
        send_sample(-24'sd3, 1'b1);
    endtask

    task automatic test_mixed_block();
        send_sample(24'h00_0001, 1'b0);
        send_sample(24'hFF_FFFF, 1'b0);
        send_sample(24'h7F_FFFF, 1'b0);
        send_sample(24'h80_0000, 1'b0);
        send_sample(24'h55_5555, 1'b0);
        send_sample(24'hAA_AAAA, 1'b0);
        send_sample(24'h00_0000, 1'b1);
    endtask

    task automatic test_long_block();
        // a lone small spike in a long quiet block pushes the crest up
        for (int i = 0; i < 199; i++)
            send_sample((i == 100) ? 24'd511 : 24'd0, 1'b0);
        send_sample(24'd0, 1'b1);
    endtask

    task automatic test_random_blocks();
        int sent;
        int len;
        sent = 0;
        while (sent < 800) begin
            len = ($urandom_range(9) < 8) ? $urandom_range(1, 24) : $urandom_range(50, 200);
            send_block(len, sample_mix_t'($urandom_range(3)));
            sent += len;
        end
    endtask

    task automatic test_steady_stream();
        steady = 1'b1;
        for (int i = 0; i < 20; i++)
            send_block($urandom_range(1, 30), sample_mix_t'($urandom_range(3)));
        steady = 1'b0;
    endtask

    task automatic test_backpressure();
        holds_asked++;
        for (int i = 0; i < 40; i++)
            send_block($urandom_range(1, 6), sample_mix_t'($urandom_range(3)));
    endtask

    // result side: random stalls, long hold on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (holds_asked != holds_served) begin
            holds_served <= holds_asked;
            hold_left    <= HOLD_CYCLES;
            m_tready     <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (steady) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= 10);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_level = m_tdata[M_FIELD_BITS-1:0];
            if (pending_levels.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
                error_count++;
            end else begin
                want_level = pending_levels.pop_front();
                check_field("rms_level", want_level.rms, seen_level.rms);
                check_field("peak_level", want_level.peak, seen_level.peak);
                check_field("peak_magnitude", want_level.mag, seen_level.mag);
                check_field("crest_ratio", want_level.crest, seen_level.crest);
            end
        end
    end

    initial begin
        aclk         = 1'b0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        m_tready     = 1'b0;
        error_count  = 0;
        steady       = 1'b0;
        holds_asked  = 0;
        holds_served = 0;
        hold_left    = 0;
        meter_sum    = '0;
        meter_count  = '0;
        meter_peak   = '0;
        meter_mag    = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_single_extremes();
        test_zero_and_negative_blocks();
        test_mixed_block();
        test_long_block();
        test_random_blocks();
        test_steady_stream();
        test_backpressure();

        s_tvalid <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (error_count == 0)
            $display("tb_audio_level_statistics: clean");
        else
            $display("tb_audio_level_statistics: errors");
        $finish;
    end

    initial begin
        #4000000;
        $display("tb_audio_level_statistics: errors");
        $finish;
    end

endmodule
